/* rtl/lage_pkg.sv */
// ----------------------------------------------------------------------------
// Life grid engine package
// Shared constants for the life grid engine: field widths, operation codes,
// register indexes and the B3/S23 rule thresholds.
// ----------------------------------------------------------------------------
package lage_pkg;

  // Default grid limits.
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Field widths of the item and configuration channels.
  localparam int OP_W      = 2;
  localparam int POS_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // Size register value after reset.
  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  // Neighbor count width and rule thresholds.
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] SURVIVE_LOW  = 4'd2;
  localparam logic [CNT_W-1:0] SURVIVE_HIGH = 4'd3;
  localparam logic [CNT_W-1:0] BIRTH_COUNT  = 4'd3;

endpackage

/* rtl/lage_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module lage_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lage_row_step.sv */
// ----------------------------------------------------------------------------
// Life grid row update
// Computes the next generation of one grid row from the old row and its two
// vertical neighbors, one lane per column. Columns outside the grid in use
// count as dead and keep their old value.
// ----------------------------------------------------------------------------
module lage_row_step #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] prev_i,
  input  logic [WIDTH-1:0] cur_i,
  input  logic [WIDTH-1:0] next_i,
  input  logic [WIDTH-1:0] col_en_i,
  output logic [WIDTH-1:0] new_o
);

  logic [WIDTH+1:0] prev_pad;
  logic [WIDTH+1:0] cur_pad;
  logic [WIDTH+1:0] next_pad;

  // Dead border on both sides; unused columns are masked to dead.
  assign prev_pad = {1'b0, prev_i & col_en_i, 1'b0};
  assign cur_pad  = {1'b0, cur_i & col_en_i, 1'b0};
  assign next_pad = {1'b0, next_i & col_en_i, 1'b0};

  for (genvar i = 0; i < WIDTH; i++) begin : g_lane
    logic [lage_pkg::CNT_W-1:0] cnt;
    logic                       alive;

    // Sum of the eight neighbors of this column.
    assign cnt = lage_pkg::CNT_W'(prev_pad[i])   + lage_pkg::CNT_W'(prev_pad[i+1])
               + lage_pkg::CNT_W'(prev_pad[i+2]) + lage_pkg::CNT_W'(cur_pad[i])
               + lage_pkg::CNT_W'(cur_pad[i+2])  + lage_pkg::CNT_W'(next_pad[i])
               + lage_pkg::CNT_W'(next_pad[i+1]) + lage_pkg::CNT_W'(next_pad[i+2]);

    // B3/S23 rule.
    assign alive = cur_i[i] ? (cnt == lage_pkg::SURVIVE_LOW || cnt == lage_pkg::SURVIVE_HIGH)
                            : (cnt == lage_pkg::BIRTH_COUNT);

    assign new_o[i] = col_en_i[i] ? alive : cur_i[i];
  end

endmodule

/* rtl/life_automaton_grid_engine.sv */
// ----------------------------------------------------------------------------
// Life grid engine
// Holds a grid of live and dead cells in a row-wide RAM and executes cell
// writes, cell reads and B3/S23 generation advances on it.
// ----------------------------------------------------------------------------
// Usage:
// Input items (opcode, x_pos, y_pos, cell_value) arrive on a valid/ready
// channel; each produces exactly one result item (cell_alive, bad_coordinate)
// on a valid/ready output channel. The grid size registers are written over a
// separate valid/ready configuration channel that is always ready; write them
// only while no item is in flight.
// A cell write or read goes through the access state and then the done state,
// which moves its result to the output register; a bad coordinate or an
// unused opcode goes straight to the done state. An advance loads row 0, then
// streams the grid one row per cycle through the RAM (one read and one write
// per cycle) before the done state. One item is in work at a time; the next is
// taken once the current result has reached the output register. After reset
// a clearing pass writes every RAM row to dead, during which no item is accepted.
// If the receiver stalls, the result waits in the output register, one more
// item may be accepted and worked on, and its result then waits internally.
// ----------------------------------------------------------------------------
module life_automaton_grid_engine #(
  parameter int MAX_WIDTH  = lage_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lage_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lage_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lage_pkg::CFG_W-1:0]     cfg_data_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lage_pkg::OP_W-1:0]      opcode_i,
  input  logic [lage_pkg::POS_W-1:0]     x_pos_i,
  input  logic [lage_pkg::POS_W-1:0]     y_pos_i,
  input  logic                           cell_value_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           cell_alive_o,
  output logic                           bad_coordinate_o
);

  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EWW = ($clog2(MAX_WIDTH + 1) > lage_pkg::CFG_W) ?
                       $clog2(MAX_WIDTH + 1) : lage_pkg::CFG_W;
  localparam int EHW = ($clog2(MAX_HEIGHT + 1) > lage_pkg::CFG_W) ?
                       $clog2(MAX_HEIGHT + 1) : lage_pkg::CFG_W;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_ACCESS   = 6'b000100,
    ST_ADV_LOAD = 6'b001000,
    ST_ADV_ROW  = 6'b010000,
    ST_DONE     = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic [RW-1:0]              row_q, row_d;
  logic [lage_pkg::CFG_W-1:0] width_q, height_q;
  logic [MAX_WIDTH-1:0]       prev_q, prev_d;
  logic [MAX_WIDTH-1:0]       cur_q, cur_d;
  logic [CW-1:0]              col_q, col_d;
  logic                       wr_q, wr_d;
  logic                       val_q, val_d;
  logic                       res_alive_q, res_alive_d;
  logic                       res_bad_q, res_bad_d;
  logic                       out_valid_q, out_valid_d;
  logic                       cell_alive_q, cell_alive_d;
  logic                       bad_q, bad_d;

  logic [EWW-1:0]       eff_w;
  logic [EHW-1:0]       eff_h;
  logic [MAX_WIDTH-1:0] col_en;
  logic                 coord_bad;
  logic                 next_in_grid;
  logic                 last_row;
  logic [MAX_WIDTH-1:0] next_row;
  logic [MAX_WIDTH-1:0] new_row;
  logic [MAX_WIDTH-1:0] patched_row;

  logic                 ram_we;
  logic [RW-1:0]        ram_waddr;
  logic [MAX_WIDTH-1:0] ram_wdata;
  logic [RW-1:0]        ram_raddr;
  logic [MAX_WIDTH-1:0] ram_rdata;

  // Configuration registers; the port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lage_pkg::SIZE_RESET;
      height_q <= lage_pkg::SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lage_pkg::REG_GRID_WIDTH:  width_q  <= cfg_data_i;
        lage_pkg::REG_GRID_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective sizes: zero counts as one, large values saturate.
  always_comb begin
    if (width_q == '0) begin
      eff_w = EWW'(1);
    end else if (EWW'(width_q) > EWW'(MAX_WIDTH)) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = EHW'(1);
    end else if (EHW'(height_q) > EHW'(MAX_HEIGHT)) begin
      eff_h = EHW'(MAX_HEIGHT);
    end else begin
      eff_h = EHW'(height_q);
    end
  end

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col_en
    assign col_en[i] = EWW'(i) < eff_w;
  end

  assign coord_bad = (EWW'(x_pos_i) >= eff_w) || (EHW'(y_pos_i) >= eff_h);

  // Row window helpers for the advance sweep.
  assign next_in_grid = (EHW'(row_q) + EHW'(1)) < eff_h;
  assign last_row     = (EHW'(row_q) + EHW'(1)) == eff_h;
  assign next_row     = next_in_grid ? ram_rdata : '0;

  lage_row_step #(
    .WIDTH (MAX_WIDTH)
  ) u_row_step (
    .prev_i   (prev_q),
    .cur_i    (cur_q),
    .next_i   (next_row),
    .col_en_i (col_en),
    .new_o    (new_row)
  );

  // Row with the addressed cell replaced, for a cell write.
  always_comb begin
    patched_row        = ram_rdata;
    patched_row[col_q] = val_q;
  end

  lage_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer: clear pass, cell access and row-by-row advance.
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    col_d       = col_q;
    wr_d        = wr_q;
    val_d       = val_q;
    res_alive_d = res_alive_q;
    res_bad_d   = res_bad_q;
    ram_we      = 1'b0;
    ram_waddr   = row_q;
    ram_wdata   = '0;
    ram_raddr   = RW'(y_pos_i);

    out_valid_d  = out_valid_q && !out_ready_i;
    cell_alive_d = cell_alive_q;
    bad_d        = bad_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = row_q;
        ram_wdata = '0;
        row_d     = row_q + RW'(1);
        if (row_q == RW'(MAX_HEIGHT - 1)) begin
          row_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          col_d       = CW'(x_pos_i);
          wr_d        = (opcode_i == lage_pkg::OP_WRITE);
          val_d       = cell_value_i;
          res_alive_d = 1'b0;
          res_bad_d   = 1'b0;
          case (opcode_i)
            lage_pkg::OP_WRITE, lage_pkg::OP_READ: begin
              ram_raddr = RW'(y_pos_i);
              row_d     = RW'(y_pos_i);
              if (coord_bad) begin
                res_bad_d = 1'b1;
                state_d   = ST_DONE;
              end else begin
                state_d = ST_ACCESS;
              end
            end
            lage_pkg::OP_ADVANCE: begin
              ram_raddr = '0;
              row_d     = '0;
              prev_d    = '0;
              state_d   = ST_ADV_LOAD;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_ACCESS: begin
        if (wr_q) begin
          ram_we      = 1'b1;
          ram_waddr   = row_q;
          ram_wdata   = patched_row;
          res_alive_d = val_q;
        end else begin
          res_alive_d = ram_rdata[col_q];
        end
        state_d = ST_DONE;
      end

      ST_ADV_LOAD: begin
        // Row 0 arrives; fetch row 1.
        cur_d     = ram_rdata;
        ram_raddr = RW'(1);
        state_d   = ST_ADV_ROW;
      end

      ST_ADV_ROW: begin
        // The old rows sit in the window, so the new row goes back in place.
        ram_we    = 1'b1;
        ram_waddr = row_q;
        ram_wdata = new_row;
        ram_raddr = row_q + RW'(2);
        prev_d    = cur_q;
        cur_d     = next_row;
        row_d     = row_q + RW'(1);
        if (last_row) begin
          row_d   = '0;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          cell_alive_d = res_alive_q;
          bad_d        = res_bad_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    prev_q       <= prev_d;
    cur_q        <= cur_d;
    col_q        <= col_d;
    wr_q         <= wr_d;
    val_q        <= val_d;
    res_alive_q  <= res_alive_d;
    res_bad_q    <= res_bad_d;
    cell_alive_q <= cell_alive_d;
    bad_q        <= bad_d;
  end

  assign out_valid_o      = out_valid_q;
  assign cell_alive_o     = cell_alive_q;
  assign bad_coordinate_o = bad_q;

  // Outside the clearing pass, only rows of the grid in use are written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != ST_CLEAR) |-> (EHW'(ram_waddr) < eff_h))
    else $error("grid RAM written beyond the rows in use");

  // The advance sweep never walks past the last row in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV_ROW) |-> (EHW'(row_q) < eff_h))
    else $error("advance row counter beyond grid height");

  // A result never flags a bad coordinate and a live cell together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cell_alive_o && bad_coordinate_o))
    else $error("result reports live cell at a bad coordinate");

  // Leaving the clearing pass, the input side opens on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && row_q == RW'(MAX_HEIGHT - 1)) |=> in_ready_o)
    else $error("input not ready after clearing pass");

endmodule
